### rtl/core/cwb_pkg.sv
// Package for the clipped window blit stream: shared types, command codes,
// register indexes and the window sequence word selector. No dependencies.
package cwb_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [15:0] CMD_COL_ADDR  = 16'h002A;
    localparam logic [15:0] CMD_ROW_ADDR  = 16'h002B;
    localparam logic [15:0] CMD_MEM_WRITE = 16'h002C;
    localparam logic [7:0]  LOW_BYTE      = 8'hFF;

    localparam logic [11:0] PANEL_WIDTH_RST  = 12'd800;
    localparam logic [11:0] PANEL_HEIGHT_RST = 12'd480;

    typedef enum logic [1:0] {
        REG_ENABLED      = 2'd0,
        REG_PANEL_WIDTH  = 2'd1,
        REG_PANEL_HEIGHT = 2'd2,
        REG_NONE         = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        WIN_COL_CMD  = 4'd0,
        WIN_X0_HI    = 4'd1,
        WIN_X0_LO    = 4'd2,
        WIN_X1_HI    = 4'd3,
        WIN_X1_LO    = 4'd4,
        WIN_ROW_CMD  = 4'd5,
        WIN_Y0_HI    = 4'd6,
        WIN_Y0_LO    = 4'd7,
        WIN_Y1_HI    = 4'd8,
        WIN_Y1_LO    = 4'd9,
        WIN_MEM_CMD  = 4'd10,
        WIN_UNUSED_A = 4'd11,
        WIN_UNUSED_B = 4'd12,
        WIN_UNUSED_C = 4'd13,
        WIN_UNUSED_D = 4'd14,
        WIN_UNUSED_E = 4'd15
    } t_win_idx;

    // window job: w0 = x0, w1 = x1, w2 = y0, w3 = y1; pixel job: w0 = pixel
    typedef struct packed {
        logic        is_window;
        logic [15:0] w0;
        logic [15:0] w1;
        logic [15:0] w2;
        logic [15:0] w3;
    } t_job;

    function automatic logic [15:0] hi_byte(input logic [15:0] v);
        return {8'd0, v[15:8]};
    endfunction

    function automatic logic [15:0] lo_byte(input logic [15:0] v);
        return {8'd0, v[7:0] & LOW_BYTE};
    endfunction

    function automatic logic [15:0] window_word(input t_job job, input t_win_idx idx);
        logic [15:0] w;
        unique case (idx)
            WIN_COL_CMD: w = CMD_COL_ADDR;
            WIN_X0_HI:   w = hi_byte(job.w0);
            WIN_X0_LO:   w = lo_byte(job.w0);
            WIN_X1_HI:   w = hi_byte(job.w1);
            WIN_X1_LO:   w = lo_byte(job.w1);
            WIN_ROW_CMD: w = CMD_ROW_ADDR;
            WIN_Y0_HI:   w = hi_byte(job.w2);
            WIN_Y0_LO:   w = lo_byte(job.w2);
            WIN_Y1_HI:   w = hi_byte(job.w3);
            WIN_Y1_LO:   w = lo_byte(job.w3);
            default:     w = CMD_MEM_WRITE;
        endcase
        return w;
    endfunction

endpackage

### rtl/core/cwb_front.sv
// Front end: accepts start and pixel items, clips rectangles, tracks the
// region position and issues jobs to the queue. Depends on cwb_pkg.
module cwb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_enabled,
    input  logic [11:0]   i_panel_width,
    input  logic [11:0]   i_panel_height,
    input  logic          i_accept,
    input  logic          i_action,
    input  logic [15:0]   i_x,
    input  logic [15:0]   i_y,
    input  logic [15:0]   i_width,
    input  logic [15:0]   i_height,
    input  logic [15:0]   i_pixel,
    output logic          o_push,
    output cwb_pkg::t_job o_job
);
    import cwb_pkg::*;

    logic        r_active, n_active;
    logic [15:0] r_clip_cols, n_clip_cols;
    logic [15:0] r_clip_rows, n_clip_rows;
    logic [15:0] r_src_cols, n_src_cols;
    logic [15:0] r_col, n_col;
    logic [15:0] r_row, n_row;

    logic [15:0] pw16, ph16;
    logic        reject;
    logic [16:0] x_end, y_end;
    logic [15:0] cw, ch;
    logic [15:0] x1, y1;
    logic        in_region;
    logic [16:0] col_inc, row_inc;

    assign pw16   = {4'd0, i_panel_width};
    assign ph16   = {4'd0, i_panel_height};
    assign reject = !i_enabled || (i_width == 16'd0) || (i_height == 16'd0)
                    || (i_x >= pw16) || (i_y >= ph16);
    assign x_end  = {1'b0, i_x} + {1'b0, i_width};
    assign y_end  = {1'b0, i_y} + {1'b0, i_height};
    assign cw     = (x_end > {1'b0, pw16}) ? (pw16 - i_x) : i_width;
    assign ch     = (y_end > {1'b0, ph16}) ? (ph16 - i_y) : i_height;
    assign x1     = i_x + cw - 16'd1;
    assign y1     = i_y + ch - 16'd1;

    assign in_region = (r_col < r_clip_cols) && (r_row < r_clip_rows);
    assign col_inc   = {1'b0, r_col} + 17'd1;
    assign row_inc   = {1'b0, r_row} + 17'd1;

    always_comb begin
        n_active    = r_active;
        n_clip_cols = r_clip_cols;
        n_clip_rows = r_clip_rows;
        n_src_cols  = r_src_cols;
        n_col       = r_col;
        n_row       = r_row;
        o_push      = 1'b0;
        o_job       = '0;
        if (i_accept && !i_action) begin
            if (reject) begin
                n_active = 1'b0;
            end else begin
                n_active       = 1'b1;
                n_clip_cols    = cw;
                n_clip_rows    = ch;
                n_src_cols     = i_width;
                n_col          = 16'd0;
                n_row          = 16'd0;
                o_push         = 1'b1;
                o_job.is_window = 1'b1;
                o_job.w0       = i_x;
                o_job.w1       = x1;
                o_job.w2       = i_y;
                o_job.w3       = y1;
            end
        end else if (i_accept && r_active) begin
            o_push   = in_region;
            o_job.w0 = i_pixel;
            if (col_inc >= {1'b0, r_src_cols}) begin
                n_col = 16'd0;
                n_row = row_inc[15:0];
                if (row_inc >= {1'b0, r_clip_rows}) begin
                    n_active = 1'b0;
                end
            end else begin
                n_col = col_inc[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_clip_cols <= '0;
            r_clip_rows <= '0;
            r_src_cols  <= '0;
            r_col       <= '0;
            r_row       <= '0;
        end else begin
            r_active    <= n_active;
            r_clip_cols <= n_clip_cols;
            r_clip_rows <= n_clip_rows;
            r_src_cols  <= n_src_cols;
            r_col       <= n_col;
            r_row       <= n_row;
        end
    end

endmodule

### rtl/core/cwb_queue.sv
// Job queue between front and back end: register-based FIFO of t_job.
// Depends on cwb_pkg.
module cwb_queue #(
    parameter int DEPTH = cwb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cwb_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output cwb_pkg::t_job o_job
);
    import cwb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

### rtl/core/cwb_back.sv
// Back end: expands queued jobs into LCD bus words and holds them in the
// output register until the receiver takes them. Depends on cwb_pkg.
module cwb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  cwb_pkg::t_job i_job,
    output logic          o_pop,
    input  logic          i_stall,
    output logic          o_valid,
    output logic [15:0]   o_bus_word,
    output logic          o_is_command,
    output logic          o_last
);
    import cwb_pkg::*;

    logic        r_valid, n_valid;
    logic [15:0] r_word, n_word;
    logic        r_is_cmd, n_is_cmd;
    logic        r_last, n_last;
    t_win_idx    r_idx, n_idx;
    logic        load;

    assign load = i_job_valid && (!r_valid || !i_stall);

    always_comb begin
        n_valid  = r_valid && i_stall;
        n_word   = r_word;
        n_is_cmd = r_is_cmd;
        n_last   = r_last;
        n_idx    = r_idx;
        o_pop    = 1'b0;
        if (load) begin
            n_valid = 1'b1;
            if (i_job.is_window) begin
                n_word   = window_word(i_job, r_idx);
                n_is_cmd = (r_idx == WIN_COL_CMD) || (r_idx == WIN_ROW_CMD)
                           || (r_idx == WIN_MEM_CMD);
                n_last   = (r_idx == WIN_MEM_CMD);
                o_pop    = (r_idx == WIN_MEM_CMD);
                n_idx    = (r_idx == WIN_MEM_CMD) ? WIN_COL_CMD : t_win_idx'(r_idx + 4'd1);
            end else begin
                n_word   = i_job.w0;
                n_is_cmd = 1'b0;
                n_last   = 1'b1;
                o_pop    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= WIN_COL_CMD;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_is_cmd <= n_is_cmd;
        r_last   <= n_last;
    end

    assign o_valid      = r_valid;
    assign o_bus_word   = r_word;
    assign o_is_command = r_is_cmd;
    assign o_last       = r_last;

    a_mid_window_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != WIN_COL_CMD) |-> (i_job_valid && i_job.is_window))
        else $error("window sequence lost its queue head");
    a_cmd_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_is_cmd) |-> ((r_word == CMD_COL_ADDR) || (r_word == CMD_ROW_ADDR)
                                   || (r_word == CMD_MEM_WRITE)))
        else $error("command flag on non-command word");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= WIN_MEM_CMD)
        else $error("window index out of range");

endmodule

### rtl/core/clipped_window_blit_stream_unit.sv
// Clipped window blit stream: top level with the register port, front end,
// job queue and back end. Depends on cwb_pkg, cwb_front, cwb_queue, cwb_back.
//
// Usage: program enabled, panel_width and panel_height over the APB port
// (byte addresses 0, 4, 8) while the block is idle. Items enter on the input
// channel (i_valid / o_stall); if enabled, a non-empty start item (action 0)
// starting on the panel opens a clipped window and yields 11 words (three
// commands with their coordinate bytes); pixel items with action 1 yield one
// data word when inside the clipped region. Words leave on the output channel
// (o_valid / i_stall) with o_is_command and o_last.
// Throughput: one pixel item per cycle while o_stall and i_stall are low; a
// start item holds the back end until all its bus words are out, while the
// front end keeps accepting into the job queue until it fills. An accepted
// item is queued; the back end loads its first word into the output register.
// o_stall rises when the job queue is full. When the receiver stalls, the
// output register holds its word and the queue absorbs up to QUEUE_DEPTH
// jobs before the input is stalled. Reset clears the region, the queue, the
// output register and loads the register defaults (disabled, 800 x 480).
module clipped_window_blit_stream_unit #(
    parameter int QUEUE_DEPTH = cwb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [15:0] i_x,
    input  logic [15:0] i_y,
    input  logic [15:0] i_width,
    input  logic [15:0] i_height,
    input  logic [15:0] i_pixel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_bus_word,
    output logic        o_is_command,
    output logic        o_last
);
    import cwb_pkg::*;

    logic        r_enabled;
    logic [11:0] r_panel_width;
    logic [11:0] r_panel_height;
    t_reg_idx    reg_idx;
    logic        cfg_write;

    logic        in_accept;
    logic        push;
    t_job        push_job;
    logic        pop;
    logic        q_full;
    logic        q_valid;
    t_job        head_job;

    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled      <= 1'b0;
            r_panel_width  <= PANEL_WIDTH_RST;
            r_panel_height <= PANEL_HEIGHT_RST;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_ENABLED:      r_enabled      <= pwdata[0];
                REG_PANEL_WIDTH:  r_panel_width  <= pwdata[11:0];
                REG_PANEL_HEIGHT: r_panel_height <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ENABLED:      prdata = {31'd0, r_enabled};
            REG_PANEL_WIDTH:  prdata = {20'd0, r_panel_width};
            REG_PANEL_HEIGHT: prdata = {20'd0, r_panel_height};
            default:          prdata = '0;
        endcase
    end

    assign o_stall   = q_full;
    assign in_accept = i_valid && !q_full;

    cwb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_enabled      (r_enabled),
        .i_panel_width  (r_panel_width),
        .i_panel_height (r_panel_height),
        .i_accept       (in_accept),
        .i_action       (i_action),
        .i_x            (i_x),
        .i_y            (i_y),
        .i_width        (i_width),
        .i_height       (i_height),
        .i_pixel        (i_pixel),
        .o_push         (push),
        .o_job          (push_job)
    );

    cwb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    cwb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (q_valid),
        .i_job        (head_job),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_bus_word   (o_bus_word),
        .o_is_command (o_is_command),
        .o_last       (o_last)
    );

endmodule
